// ===== design/rsgt_pkg.sv =====
package rsgt_pkg;

  localparam int SEQ_W = 16;
  localparam int CNT_W = 32;
  localparam logic [SEQ_W-1:0] HALF_WINDOW = 16'h8000;
  localparam logic [SEQ_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [SEQ_W-1:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_WAITING    = 2'd1,
    MODE_RECOVERING = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    EV_FIRST       = 4'd0,
    EV_IN_ORDER    = 4'd1,
    EV_GAP_OPENED  = 4'd2,
    EV_STALE       = 4'd3,
    EV_FILLED      = 4'd4,
    EV_LOST_NEW    = 4'd5,
    EV_LOST_RESUME = 4'd6,
    EV_TIMEOUT     = 4'd7,
    EV_RESUME      = 4'd8,
    EV_IDLE_TICK   = 4'd9
  } event_t;

  // op codes of an input beat
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    mode_t            mode;
    logic             started;
    logic [SEQ_W-1:0] expected;
    logic [SEQ_W-1:0] hole_first;
    logic [SEQ_W-1:0] hole_last;
    logic [SEQ_W-1:0] elapsed;
  } track_state_t;

  typedef struct packed {
    logic seen;
    logic stale;
    logic opened;
    logic filled;
    logic lost;
  } stat_inc_t;

  typedef struct packed {
    logic             valid;
    logic             recovered;
    logic [SEQ_W-1:0] start;
    logic [SEQ_W-1:0] last;
  } closed_span_t;

  // a is after b in the modular half window
  function automatic logic seq_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d < HALF_WINDOW) && (a != b);
  endfunction

endpackage

// ===== design/rtp_sequence_gap_tracker_top.sv =====
// RTP sequence gap tracker. Each input beat is either a packet carrying a
// 16-bit sequence number (op 0) or a one millisecond tick (op 1), and each
// one yields exactly one result beat with the tracker mode after the step,
// an event code, the gap record closed by the step (if any), the expected
// sequence number and five wrapping 32-bit statistics counters. Sequence
// numbers are compared in a modular half window. A beat goes through an
// input register, one pass of compare and increment logic, and a result
// register, so one beat is taken every cycle while the input is not stalled;
// the result is presented once the beat has passed through the input
// register and the result register. The input stalls only while both
// registers hold a beat and the result is stalled. timeout_ticks is
// written over its own valid/ready port (always ready, reset value 100)
// and should be changed only while no beat is in flight.
module rtp_sequence_gap_tracker_top (
  input  logic                       clk,
  input  logic                       rst,

  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rsgt_pkg::SEQ_W-1:0] timeout_ticks,

  // input beats
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       op,
  input  logic [rsgt_pkg::SEQ_W-1:0] seq,

  // result beats
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 fsm_state,
  output logic [3:0]                 event_res,
  output logic                       record_valid,
  output logic                       record_recovered,
  output logic [rsgt_pkg::SEQ_W-1:0] record_start,
  output logic [rsgt_pkg::SEQ_W-1:0] record_end,
  output logic [rsgt_pkg::SEQ_W-1:0] expected_seq,
  output logic [rsgt_pkg::CNT_W-1:0] packets_seen,
  output logic [rsgt_pkg::CNT_W-1:0] stale_count,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_opened,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_filled,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_lost
);

  // configured timeout
  logic [rsgt_pkg::SEQ_W-1:0] timeout_reg;

  // input register
  logic                       in_full;
  logic                       in_op;
  logic [rsgt_pkg::SEQ_W-1:0] in_seq;

  // result register
  logic                       res_full;
  rsgt_pkg::event_t           res_ev;
  rsgt_pkg::closed_span_t     res_rec;

  // tracker state
  rsgt_pkg::track_state_t     state;
  rsgt_pkg::track_state_t     state_next;
  rsgt_pkg::event_t           ev_next;
  rsgt_pkg::closed_span_t     rec_next;
  rsgt_pkg::stat_inc_t        inc_next;

  logic                       res_free;
  logic                       process;

  assign cfg_ready = 1'b1;

  // result slot can take a new beat when empty or being drained
  assign res_free = !res_full || !out_stall;
  // the beat in the input register is worked off into the result register
  assign process  = in_full && res_free;
  // input register holds a beat that cannot move on
  assign in_stall = in_full && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reg <= rsgt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_reg <= timeout_ticks;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op  <= op;
      in_seq <= seq;
    end
  end

  rsgt_step u_step (
    .op            (in_op),
    .seq           (in_seq),
    .timeout_ticks (timeout_reg),
    .state         (state),
    .state_next    (state_next),
    .ev            (ev_next),
    .rec           (rec_next),
    .inc           (inc_next)
  );

  // tracker state moves only when a beat enters the result register, so
  // the state and counters seen at the outputs always match the shown beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode:       rsgt_pkg::MODE_NORMAL,
                 started:    1'b0,
                 expected:   '0,
                 hole_first: '0,
                 hole_last:  '0,
                 elapsed:    '0};
    end else if (process) begin
      state <= state_next;
    end
  end

  rsgt_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .en           (process),
    .inc          (inc_next),
    .packets_seen (packets_seen),
    .stale_count  (stale_count),
    .gaps_opened  (gaps_opened),
    .gaps_filled  (gaps_filled),
    .gaps_lost    (gaps_lost)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (res_free) begin
      res_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_ev  <= ev_next;
      res_rec <= rec_next;
    end
  end

  assign out_valid        = res_full;
  assign fsm_state        = state.mode;
  assign event_res        = res_ev;
  assign record_valid     = res_rec.valid;
  assign record_recovered = res_rec.recovered;
  assign record_start     = res_rec.start;
  assign record_end       = res_rec.last;
  assign expected_seq     = state.expected;

endmodule

// ===== design/rsgt_step.sv =====
module rsgt_step (
  input  logic                        op,
  input  logic [rsgt_pkg::SEQ_W-1:0]  seq,
  input  logic [rsgt_pkg::SEQ_W-1:0]  timeout_ticks,
  input  rsgt_pkg::track_state_t      state,
  output rsgt_pkg::track_state_t      state_next,
  output rsgt_pkg::event_t            ev,
  output rsgt_pkg::closed_span_t      rec,
  output rsgt_pkg::stat_inc_t         inc
);

  logic [rsgt_pkg::SEQ_W-1:0] seq_plus1;
  logic [rsgt_pkg::SEQ_W-1:0] resume;
  logic [rsgt_pkg::SEQ_W-1:0] elapsed_inc;
  logic                       in_hole;
  logic                       past_hole;

  assign seq_plus1   = seq + 16'd1;
  assign resume      = state.hole_last + 16'd1;
  assign in_hole     = !rsgt_pkg::seq_after(state.hole_first, seq)
                       && !rsgt_pkg::seq_after(seq, state.hole_last);
  assign past_hole   = rsgt_pkg::seq_after(seq, state.hole_last);
  assign elapsed_inc = (state.elapsed == rsgt_pkg::ELAPSED_MAX) ? state.elapsed
                                                                 : state.elapsed + 16'd1;

  always_comb begin
    state_next = state;
    ev         = rsgt_pkg::EV_IDLE_TICK;
    rec        = '0;
    inc        = '0;
    if (op == rsgt_pkg::OP_PACKET) begin
      inc.seen = 1'b1;
      case (state.mode)
        rsgt_pkg::MODE_WAITING: begin
          if (in_hole) begin
            inc.filled          = 1'b1;
            rec                 = {1'b1, 1'b1, state.hole_first, state.hole_last};
            state_next.expected = resume;
            state_next.mode     = rsgt_pkg::MODE_NORMAL;
            ev                  = rsgt_pkg::EV_FILLED;
          end else if (past_hole) begin
            inc.lost = 1'b1;
            rec      = {1'b1, 1'b0, state.hole_first, state.hole_last};
            if (rsgt_pkg::seq_after(seq, resume)) begin
              // nested gap right behind the lost one
              inc.opened            = 1'b1;
              state_next.hole_first = resume;
              state_next.hole_last  = seq - 16'd1;
              state_next.elapsed    = '0;
              state_next.expected   = seq_plus1;
              ev                    = rsgt_pkg::EV_LOST_NEW;
            end else begin
              state_next.expected = seq_plus1;
              state_next.mode     = rsgt_pkg::MODE_NORMAL;
              ev                  = rsgt_pkg::EV_LOST_RESUME;
            end
          end else begin
            inc.stale = 1'b1;
            ev        = rsgt_pkg::EV_STALE;
          end
        end
        rsgt_pkg::MODE_RECOVERING: begin
          state_next.expected = seq_plus1;
          state_next.mode     = rsgt_pkg::MODE_NORMAL;
          ev                  = rsgt_pkg::EV_RESUME;
        end
        default: begin
          // normal, and the unused mode code treated alike
          state_next.mode = rsgt_pkg::MODE_NORMAL;
          if (!state.started) begin
            state_next.expected = seq_plus1;
            state_next.started  = 1'b1;
            ev                  = rsgt_pkg::EV_FIRST;
          end else if (seq == state.expected) begin
            state_next.expected = seq_plus1;
            ev                  = rsgt_pkg::EV_IN_ORDER;
          end else if (rsgt_pkg::seq_after(seq, state.expected)) begin
            inc.opened            = 1'b1;
            state_next.hole_first = state.expected;
            state_next.hole_last  = seq - 16'd1;
            state_next.elapsed    = '0;
            state_next.expected   = seq_plus1;
            state_next.mode       = rsgt_pkg::MODE_WAITING;
            ev                    = rsgt_pkg::EV_GAP_OPENED;
          end else begin
            inc.stale = 1'b1;
            ev        = rsgt_pkg::EV_STALE;
          end
        end
      endcase
    end else if (state.mode == rsgt_pkg::MODE_WAITING) begin
      state_next.elapsed = elapsed_inc;
      if (elapsed_inc >= timeout_ticks) begin
        inc.lost        = 1'b1;
        rec             = {1'b1, 1'b0, state.hole_first, state.hole_last};
        state_next.mode = rsgt_pkg::MODE_RECOVERING;
        ev              = rsgt_pkg::EV_TIMEOUT;
      end
    end
  end

endmodule

// ===== design/rsgt_stats.sv =====
module rsgt_stats (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rsgt_pkg::stat_inc_t        inc,
  output logic [rsgt_pkg::CNT_W-1:0] packets_seen,
  output logic [rsgt_pkg::CNT_W-1:0] stale_count,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_opened,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_filled,
  output logic [rsgt_pkg::CNT_W-1:0] gaps_lost
);

  // wrapping counters, each bumped at most once per processed beat when its flag is set
  always_ff @(posedge clk) begin
    if (rst) begin
      packets_seen <= '0;
      stale_count  <= '0;
      gaps_opened  <= '0;
      gaps_filled  <= '0;
      gaps_lost    <= '0;
    end else if (en) begin
      if (inc.seen)   packets_seen <= packets_seen + 32'd1;
      if (inc.stale)  stale_count  <= stale_count + 32'd1;
      if (inc.opened) gaps_opened  <= gaps_opened + 32'd1;
      if (inc.filled) gaps_filled  <= gaps_filled + 32'd1;
      if (inc.lost)   gaps_lost    <= gaps_lost + 32'd1;
    end
  end

endmodule

// ===== tb/tb_rtp_sequence_gap_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_rtp_sequence_gap_tracker_top;

  localparam int SEQ_W = rsgt_pkg::SEQ_W;
  localparam int CNT_W = rsgt_pkg::CNT_W;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // one result beat as the tracker should present it
  typedef struct packed {
    rsgt_pkg::mode_t        mode;
    rsgt_pkg::event_t       ev;
    rsgt_pkg::closed_span_t rec;
    logic [SEQ_W-1:0]       next;
    logic [CNT_W-1:0]       seen;
    logic [CNT_W-1:0]       stale;
    logic [CNT_W-1:0]       opened;
    logic [CNT_W-1:0]       filled;
    logic [CNT_W-1:0]       lost;
  } tracker_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SEQ_W-1:0] timeout_ticks = rsgt_pkg::TIMEOUT_RESET;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             op = rsgt_pkg::OP_PACKET;
  logic [SEQ_W-1:0] seq = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       fsm_state;
  logic [3:0]       event_res;
  logic             record_valid;
  logic             record_recovered;
  logic [SEQ_W-1:0] record_start;
  logic [SEQ_W-1:0] record_end;
  logic [SEQ_W-1:0] expected_seq;
  logic [CNT_W-1:0] packets_seen;
  logic [CNT_W-1:0] stale_count;
  logic [CNT_W-1:0] gaps_opened;
  logic [CNT_W-1:0] gaps_filled;
  logic [CNT_W-1:0] gaps_lost;

  rtp_sequence_gap_tracker_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .timeout_ticks    (timeout_ticks),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .seq              (seq),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .fsm_state        (fsm_state),
    .event_res        (event_res),
    .record_valid     (record_valid),
    .record_recovered (record_recovered),
    .record_start     (record_start),
    .record_end       (record_end),
    .expected_seq     (expected_seq),
    .packets_seen     (packets_seen),
    .stale_count      (stale_count),
    .gaps_opened      (gaps_opened),
    .gaps_filled      (gaps_filled),
    .gaps_lost        (gaps_lost)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // tracker mirror: state, configured limit and statistics
  // ---------------------------------------------------------------------
  rsgt_pkg::mode_t  trk_mode;
  logic             trk_started;
  logic [SEQ_W-1:0] trk_expected;
  logic [SEQ_W-1:0] trk_hole_first;
  logic [SEQ_W-1:0] trk_hole_last;
  logic [SEQ_W-1:0] trk_elapsed;
  logic [SEQ_W-1:0] trk_limit;
  logic [CNT_W-1:0] n_seen, n_stale, n_opened, n_filled, n_lost;

  tracker_beat_t    expected_beats[$];
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;
  bit               calm = 1'b0;      // no new idling started on either side while set
  int unsigned      stall_left = 0;

  // stimulus stream for the random part
  logic [SEQ_W-1:0] stream_seq;
  logic [SEQ_W-1:0] miss_lo;
  logic [SEQ_W-1:0] miss_n;
  int unsigned      hole_pending = 0;

  task automatic tracker_reset();
    trk_mode       = rsgt_pkg::MODE_NORMAL;
    trk_started    = 1'b0;
    trk_expected   = '0;
    trk_hole_first = '0;
    trk_hole_last  = '0;
    trk_elapsed    = '0;
    trk_limit      = rsgt_pkg::TIMEOUT_RESET;
    n_seen   = '0;
    n_stale  = '0;
    n_opened = '0;
    n_filled = '0;
    n_lost   = '0;
  endtask

  // a comes after b: nonzero forward distance inside the half window
  function automatic logic is_later(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return (diff != '0) && !diff[SEQ_W-1];
  endfunction

  // new hole from first up to just before s, expect the number after s
  function automatic void open_gap(input logic [SEQ_W-1:0] first,
                                   input logic [SEQ_W-1:0] s);
    trk_hole_first = first;
    trk_hole_last  = s - 1'b1;
    n_opened       = n_opened + 1'b1;
    trk_elapsed    = '0;
    trk_expected   = s + 1'b1;
  endfunction

  function automatic tracker_beat_t track_step(input logic o, input logic [SEQ_W-1:0] s);
    tracker_beat_t    r;
    logic [SEQ_W-1:0] resume;
    r = '0;
    r.ev = rsgt_pkg::EV_IDLE_TICK;
    if (o == rsgt_pkg::OP_PACKET) begin
      n_seen = n_seen + 1'b1;
      if (trk_mode == rsgt_pkg::MODE_WAITING) begin
        resume = trk_hole_last + 1'b1;
        if (!is_later(trk_hole_first, s) && !is_later(s, trk_hole_last)) begin
          // late packet lands inside the hole
          n_filled     = n_filled + 1'b1;
          r.rec        = '{valid: 1'b1, recovered: 1'b1, start: trk_hole_first,
                           last: trk_hole_last};
          trk_expected = resume;
          trk_mode     = rsgt_pkg::MODE_NORMAL;
          r.ev         = rsgt_pkg::EV_FILLED;
        end else if (is_later(s, trk_hole_last)) begin
          // hole given up, maybe a nested one behind it
          n_lost = n_lost + 1'b1;
          r.rec  = '{valid: 1'b1, recovered: 1'b0, start: trk_hole_first,
                     last: trk_hole_last};
          if (is_later(s, resume)) begin
            open_gap(resume, s);
            r.ev = rsgt_pkg::EV_LOST_NEW;
          end else begin
            trk_expected = s + 1'b1;
            trk_mode     = rsgt_pkg::MODE_NORMAL;
            r.ev         = rsgt_pkg::EV_LOST_RESUME;
          end
        end else begin
          n_stale = n_stale + 1'b1;
          r.ev    = rsgt_pkg::EV_STALE;
        end
      end else if (trk_mode == rsgt_pkg::MODE_RECOVERING) begin
        trk_expected = s + 1'b1;
        trk_mode     = rsgt_pkg::MODE_NORMAL;
        r.ev         = rsgt_pkg::EV_RESUME;
      end else begin
        trk_mode = rsgt_pkg::MODE_NORMAL;
        if (!trk_started) begin
          trk_expected = s + 1'b1;
          trk_started  = 1'b1;
          r.ev         = rsgt_pkg::EV_FIRST;
        end else if (s == trk_expected) begin
          trk_expected = s + 1'b1;
          r.ev         = rsgt_pkg::EV_IN_ORDER;
        end else if (is_later(s, trk_expected)) begin
          open_gap(trk_expected, s);
          trk_mode = rsgt_pkg::MODE_WAITING;
          r.ev     = rsgt_pkg::EV_GAP_OPENED;
        end else begin
          n_stale = n_stale + 1'b1;
          r.ev    = rsgt_pkg::EV_STALE;
        end
      end
    end else if (trk_mode == rsgt_pkg::MODE_WAITING) begin
      // millisecond tick, elapsed time saturates
      if (trk_elapsed != rsgt_pkg::ELAPSED_MAX) trk_elapsed = trk_elapsed + 1'b1;
      if (trk_elapsed >= trk_limit) begin
        n_lost   = n_lost + 1'b1;
        r.rec    = '{valid: 1'b1, recovered: 1'b0, start: trk_hole_first,
                     last: trk_hole_last};
        trk_mode = rsgt_pkg::MODE_RECOVERING;
        r.ev     = rsgt_pkg::EV_TIMEOUT;
      end
    end
    r.mode   = trk_mode;
    r.next   = trk_expected;
    r.seen   = n_seen;
    r.stale  = n_stale;
    r.opened = n_opened;
    r.filled = n_filled;
    r.lost   = n_lost;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // idle lengths: mostly short, now and then a long stretch
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_idle();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // receiver backpressure, changed only at the rising edge
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_idle() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  // present one beat, predict it on acceptance, then maybe go idle;
  // valid stays high when no gap follows so back to back beats stream
  task automatic send_beat(input logic o, input logic [SEQ_W-1:0] s);
    int unsigned gap;
    in_valid <= 1'b1;
    op       <= o;
    seq      <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(track_step(o, s));
    gap = 0;
    if (!calm && $urandom_range(0, 1) == 1) gap = pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    // pipeline is two deep, the extra wait catches stray beats
    repeat (3) @(posedge clk);
  endtask

  // limit register only changes while nothing is in flight
  task automatic write_timeout(input logic [SEQ_W-1:0] limit);
    wait_drained();
    cfg_valid     <= 1'b1;
    timeout_ticks <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    trk_limit = limit;
  endtask

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tracker_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no input beat outstanding");
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("fsm_state", CNT_W'(want.mode), CNT_W'(fsm_state));
        check_field("event_res", CNT_W'(want.ev), CNT_W'(event_res));
        check_field("record_valid", CNT_W'(want.rec.valid), CNT_W'(record_valid));
        check_field("record_recovered", CNT_W'(want.rec.recovered),
                    CNT_W'(record_recovered));
        check_field("record_start", CNT_W'(want.rec.start), CNT_W'(record_start));
        check_field("record_end", CNT_W'(want.rec.last), CNT_W'(record_end));
        check_field("expected_seq", CNT_W'(want.next), CNT_W'(expected_seq));
        check_field("packets_seen", want.seen, packets_seen);
        check_field("stale_count", want.stale, stale_count);
        check_field("gaps_opened", want.opened, gaps_opened);
        check_field("gaps_filled", want.filled, gaps_filled);
        check_field("gaps_lost", want.lost, gaps_lost);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // packet paths with the reset limit: bootstrap across the wrap, in order,
  // duplicate, half window edge, fill, stale while waiting, lost with
  // resume and lost with a nested one-number hole
  task automatic test_directed_packets();
    send_beat(rsgt_pkg::OP_PACKET, 16'hFFFF);   // first packet, expected wraps to 0
    send_beat(rsgt_pkg::OP_PACKET, 16'h0000);   // in order
    send_beat(rsgt_pkg::OP_PACKET, 16'h0000);   // duplicate
    send_beat(rsgt_pkg::OP_PACKET, 16'h0001);
    send_beat(rsgt_pkg::OP_PACKET, 16'h8002);   // exactly half a window ahead: stale
    send_beat(rsgt_pkg::OP_PACKET, 16'h8001);   // just inside the window: big hole
    send_beat(rsgt_pkg::OP_TICK,   16'hFFFF);   // tick below limit, seq ignored
    send_beat(rsgt_pkg::OP_PACKET, 16'h4000);   // fills the hole
    send_beat(rsgt_pkg::OP_PACKET, 16'h8001);
    send_beat(rsgt_pkg::OP_PACKET, 16'h8005);   // hole 8002..8004
    send_beat(rsgt_pkg::OP_PACKET, 16'h8000);   // before the hole: stale
    send_beat(rsgt_pkg::OP_PACKET, 16'h8005);   // right after the hole: lost, resume
    send_beat(rsgt_pkg::OP_PACKET, 16'h8010);   // hole 8006..800f
    send_beat(rsgt_pkg::OP_PACKET, 16'h8011);   // lost, nested hole of one number
    send_beat(rsgt_pkg::OP_PACKET, 16'h8010);   // fills the nested hole
    send_beat(rsgt_pkg::OP_PACKET, 16'h8011);
  endtask

  // tick paths: idle ticks, timeout to recovering, re-anchor, zero limit
  task automatic test_directed_timeouts();
    write_timeout(16'd2);
    send_beat(rsgt_pkg::OP_TICK,   16'h0000);   // tick in normal
    send_beat(rsgt_pkg::OP_PACKET, 16'h8020);
    send_beat(rsgt_pkg::OP_TICK,   16'h0000);
    send_beat(rsgt_pkg::OP_TICK,   16'h0000);   // limit reached
    send_beat(rsgt_pkg::OP_TICK,   16'h0000);   // tick in recovering
    send_beat(rsgt_pkg::OP_PACKET, 16'h1234);   // re-anchor
    write_timeout(16'd0);
    send_beat(rsgt_pkg::OP_PACKET, 16'h1240);
    send_beat(rsgt_pkg::OP_TICK,   16'h0000);   // zero limit: first tick times out
    send_beat(rsgt_pkg::OP_PACKET, 16'hFFFF);   // re-anchor, expected wraps to 0
  endtask

  // largest limit: ticks keep counting without a timeout, then a fill
  task automatic test_long_limit();
    write_timeout(rsgt_pkg::ELAPSED_MAX);
    calm = 1'b1;
    send_beat(rsgt_pkg::OP_PACKET, trk_expected + 16'd7);
    repeat (20) send_beat(rsgt_pkg::OP_TICK, 16'h5A5A);
    send_beat(rsgt_pkg::OP_PACKET, trk_hole_first);   // late fill
    wait_drained();
    calm = 1'b0;
  endtask

  // one random beat: mostly an in-order stream with holes that are
  // refilled late or timed out, plus duplicates, wide jumps and noise
  task automatic send_random_beat();
    int unsigned      pick;
    logic [SEQ_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (hole_pending != 0) begin
      // right after a hole: ticks and late packets from the missing range
      hole_pending--;
      if (pick < 40) begin
        s = miss_lo + SEQ_W'($urandom_range(0, int'(miss_n) - 1));
        send_beat(rsgt_pkg::OP_PACKET, s);
      end else begin
        send_beat(rsgt_pkg::OP_TICK, SEQ_W'($urandom()));
      end
    end else begin
      // now and then follow the tracker again after noise
      if ($urandom_range(0, 9) == 0) stream_seq = trk_expected;
      if (pick < 18) begin
        send_beat(rsgt_pkg::OP_TICK, SEQ_W'($urandom()));
      end else if (pick < 55) begin
        send_beat(rsgt_pkg::OP_PACKET, stream_seq);
        stream_seq = stream_seq + 1'b1;
      end else if (pick < 72) begin
        miss_lo      = stream_seq;
        miss_n       = SEQ_W'($urandom_range(1, 8));
        stream_seq   = stream_seq + miss_n;
        hole_pending = $urandom_range(0, 6);
        send_beat(rsgt_pkg::OP_PACKET, stream_seq);
        stream_seq = stream_seq + 1'b1;
      end else if (pick < 84) begin
        send_beat(rsgt_pkg::OP_PACKET, stream_seq - SEQ_W'($urandom_range(1, 12)));
      end else if (pick < 90) begin
        // around half a window ahead
        stream_seq = stream_seq + 16'h7FFE + SEQ_W'($urandom_range(0, 3));
        send_beat(rsgt_pkg::OP_PACKET, stream_seq);
        stream_seq = stream_seq + 1'b1;
      end else if (pick < 95) begin
        s = SEQ_W'($urandom());
        send_beat(rsgt_pkg::OP_PACKET, s);
        if (pick[0]) stream_seq = s + 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       s = 16'h0000;
          1:       s = 16'hFFFF;
          2:       s = 16'h8000;
          default: s = 16'h7FFF;
        endcase
        send_beat(rsgt_pkg::OP_PACKET, s);
      end
    end
  endtask

  // phases with different limits, one of them without any idling
  task automatic test_random_traffic();
    logic [SEQ_W-1:0] limit;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       limit = 16'd1;
        1:       limit = 16'd3;
        2:       limit = 16'd0;
        3:       limit = 16'd8;
        4:       limit = rsgt_pkg::ELAPSED_MAX;
        default: limit = SEQ_W'($urandom_range(2, 20));
      endcase
      write_timeout(limit);
      calm         = (ph == 3);
      stream_seq   = trk_expected;
      hole_pending = 0;
      repeat (200) send_random_beat();
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL rtp_sequence_gap_tracker_top");
    $finish;
  end

  initial begin
    tracker_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_directed_timeouts();
    test_long_limit();
    test_random_traffic();
    wait_drained();
    if (errors == 0 && expected_beats.size() == 0)
      $display("PASS rtp_sequence_gap_tracker_top");
    else
      $display("FAIL rtp_sequence_gap_tracker_top");
    $finish;
  end

endmodule
